FILE: rtl/acpe_pkg.sv
`timescale 1ns / 1ps

package acpe_pkg;

   localparam int TYPE_COUNT      = 32;
   localparam int TYPE_FIELD_BITS = 5;
   localparam int TYPE_BITS       = $clog2(TYPE_COUNT);
   localparam int COORD_BITS      = 16;
   localparam int ENTRY_BITS      = 16;
   localparam int DIFF_BITS       = COORD_BITS + 1;
   localparam int SQ_BITS         = 2 * DIFF_BITS;
   localparam int DSQ_BITS        = SQ_BITS + 2;
   localparam int SUM_BITS        = 48;
   localparam int CUT_BITS        = 24;
   localparam int TADDR_BITS      = 1 + 2 * TYPE_BITS;

   localparam logic [CUT_BITS-1:0] RESIDUE_CUT_RESET = 24'd2363392;
   localparam logic [CUT_BITS-1:0] ATOM_CUT_RESET    = 24'd155648;
   localparam logic [CUT_BITS-1:0] INNER_RESET       = 24'd65536;
   localparam logic [CUT_BITS-1:0] OUTER_RESET       = 24'd147456;

   typedef enum logic [1:0] {
      ACT_RESIDUE = 2'd0,
      ACT_ATOM    = 2'd1,
      ACT_TABLE   = 2'd2,
      ACT_NONE    = 2'd3
   } action_type;

   typedef enum logic [2:0] {
      REG_MODEL       = 3'd0,
      REG_RESIDUE_CUT = 3'd1,
      REG_ATOM_CUT    = 3'd2,
      REG_INNER       = 3'd3,
      REG_OUTER       = 3'd4
   } csr_index_type;

   typedef struct packed {
      logic                         en;
      logic                         outer;
      logic [TADDR_BITS-1:0]        addr;
      logic signed [ENTRY_BITS-1:0] data;
   } tbl_wr_type;

   typedef struct packed {
      logic                  en;
      logic [TADDR_BITS-1:0] addr;
   } tbl_rd_type;

endpackage

FILE: rtl/atom_pair_contact_energy_top.sv
`timescale 1ns / 1ps
// channel | direction | handshake              | payload
// req     | in        | req_valid / req_stall  | action, coordinates, types, table fields, last
// rsp     | out       | rsp_valid / rsp_stall  | total_energy
// csr     | in        | csr_valid / csr_ready  | index, data
//
// One item per cycle sustained while no result is stalled. A result passes through four
// registers after its last beat is accepted: input/table-read, squares, distance compare,
// accumulator.
// Table writes are registered; a following atom pair reads the new entry.
// Reset is synchronous; config returns to defaults, sum cleared, gate closed.
// Table contents are not reset. A stalled result backs up stage by stage.

module atom_pair_contact_energy_top
   import acpe_pkg::*;
(
   input  logic                         clock,
   input  logic                         reset,

   input  logic                         req_valid,
   output logic                         req_stall,
   input  logic [1:0]                   req_action,
   input  logic signed [15:0]           req_receptor_x,
   input  logic signed [15:0]           req_receptor_y,
   input  logic signed [15:0]           req_receptor_z,
   input  logic signed [15:0]           req_ligand_x,
   input  logic signed [15:0]           req_ligand_y,
   input  logic signed [15:0]           req_ligand_z,
   input  logic [TYPE_FIELD_BITS-1:0]   req_receptor_type,
   input  logic [TYPE_FIELD_BITS-1:0]   req_ligand_type,
   input  logic [1:0]                   req_table_select,
   input  logic signed [15:0]           req_table_value,
   input  logic                         req_last,

   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic signed [SUM_BITS-1:0]   rsp_total_energy,

   input  logic                         csr_valid,
   output logic                         csr_ready,
   input  logic [2:0]                   csr_index,
   input  logic [CUT_BITS-1:0]          csr_data
);

   // configuration
   logic                model_ff;
   logic [CUT_BITS-1:0] residue_cut_ff;
   logic [CUT_BITS-1:0] atom_cut_ff;
   logic [CUT_BITS-1:0] inner_cut_ff;
   logic [CUT_BITS-1:0] outer_cut_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         model_ff       <= 1'b1;
         residue_cut_ff <= RESIDUE_CUT_RESET;
         atom_cut_ff    <= ATOM_CUT_RESET;
         inner_cut_ff   <= INNER_RESET;
         outer_cut_ff   <= OUTER_RESET;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index_type'(csr_index))
            REG_MODEL:       model_ff       <= csr_data[0];
            REG_RESIDUE_CUT: residue_cut_ff <= csr_data;
            REG_ATOM_CUT:    atom_cut_ff    <= csr_data;
            REG_INNER:       inner_cut_ff   <= csr_data;
            REG_OUTER:       outer_cut_ff   <= csr_data;
            default: ;
         endcase
      end
   end

   // stage enables
   logic a_v_ff, b_v_ff, c_v_ff, o_v_ff;
   logic a_en, b_en, c_en, o_en;
   logic c_last_ff;
   logic accept;

   assign o_en      = !o_v_ff || !rsp_stall;
   assign c_en      = !c_v_ff || !c_last_ff || o_en;
   assign b_en      = !b_v_ff || c_en;
   assign a_en      = !a_v_ff || b_en;
   assign req_stall = !a_en;
   assign accept    = req_valid && !req_stall;

   // table
   logic                         types_ok;
   logic [TADDR_BITS-1:0]        pair_addr;
   tbl_wr_type                   tbl_wr;
   tbl_rd_type                   tbl_rd;
   logic signed [ENTRY_BITS-1:0] rd_inner;
   logic signed [ENTRY_BITS-1:0] rd_outer;
   action_type                   req_act;

   assign req_act   = action_type'(req_action);
   assign types_ok  = ({1'b0, req_receptor_type} < (TYPE_FIELD_BITS+1)'(TYPE_COUNT)) &&
                      ({1'b0, req_ligand_type} < (TYPE_FIELD_BITS+1)'(TYPE_COUNT));
   assign pair_addr = {model_ff, req_receptor_type[TYPE_BITS-1:0],
                       req_ligand_type[TYPE_BITS-1:0]};

   always_comb begin
      tbl_wr.en    = accept && (req_act == ACT_TABLE) && types_ok;
      tbl_wr.outer = req_table_select[0];
      tbl_wr.addr  = {req_table_select[1], req_receptor_type[TYPE_BITS-1:0],
                      req_ligand_type[TYPE_BITS-1:0]};
      tbl_wr.data  = ENTRY_BITS'(req_table_value);
      tbl_rd.en    = accept && (req_act == ACT_ATOM);
      tbl_rd.addr  = pair_addr;
   end

   acpe_table u_table (
      .clock    (clock),
      .wr       (tbl_wr),
      .rd       (tbl_rd),
      .rd_inner (rd_inner),
      .rd_outer (rd_outer)
   );

   // stage A: input register
   logic                         a_atom_ff, a_last_ff, a_ok_ff;
   logic signed [COORD_BITS-1:0] a_rec_ff [3];
   logic signed [COORD_BITS-1:0] a_lig_ff [3];
   logic                         a_load;

   assign a_load = accept && (req_act == ACT_RESIDUE || req_act == ACT_ATOM);

   always_ff @(posedge clock) begin
      if (reset) begin
         a_v_ff <= 1'b0;
      end else if (a_en) begin
         a_v_ff <= a_load;
      end
      if (a_en && a_load) begin
         a_atom_ff   <= (req_act == ACT_ATOM);
         a_last_ff   <= req_last;
         a_ok_ff     <= types_ok;
         a_rec_ff[0] <= req_receptor_x[COORD_BITS-1:0];
         a_rec_ff[1] <= req_receptor_y[COORD_BITS-1:0];
         a_rec_ff[2] <= req_receptor_z[COORD_BITS-1:0];
         a_lig_ff[0] <= req_ligand_x[COORD_BITS-1:0];
         a_lig_ff[1] <= req_ligand_y[COORD_BITS-1:0];
         a_lig_ff[2] <= req_ligand_z[COORD_BITS-1:0];
      end
   end

   // stage B: per-axis squares
   logic signed [DIFF_BITS-1:0]  diff [3];
   logic signed [SQ_BITS-1:0]    sq_in [3];
   logic [SQ_BITS-1:0]           b_sq_ff [3];
   logic                         b_atom_ff, b_last_ff, b_ok_ff;
   logic signed [ENTRY_BITS-1:0] b_inner_ff, b_outer_ff;

   always_comb begin
      for (int k = 0; k < 3; k++) begin
         diff[k]  = DIFF_BITS'(a_lig_ff[k]) - DIFF_BITS'(a_rec_ff[k]);
         sq_in[k] = SQ_BITS'(diff[k]) * SQ_BITS'(diff[k]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         b_v_ff <= 1'b0;
      end else if (b_en) begin
         b_v_ff <= a_v_ff;
      end
      if (b_en && a_v_ff) begin
         for (int k = 0; k < 3; k++) begin
            b_sq_ff[k] <= sq_in[k];
         end
         b_atom_ff  <= a_atom_ff;
         b_last_ff  <= a_last_ff;
         b_ok_ff    <= a_ok_ff;
         b_inner_ff <= rd_inner;
         b_outer_ff <= rd_outer;
      end
   end

   // stage C: distance compare, gate, addend
   logic [DSQ_BITS-1:0]          dsq;
   logic                         in_atom, in_inner, in_outer, hit;
   logic signed [ENTRY_BITS-1:0] addend_in;
   logic signed [ENTRY_BITS-1:0] c_add_ff;
   logic                         gate_ff;
   logic                         b_fire;

   assign dsq      = DSQ_BITS'(b_sq_ff[0]) + DSQ_BITS'(b_sq_ff[1]) + DSQ_BITS'(b_sq_ff[2]);
   assign in_atom  = dsq <= DSQ_BITS'(atom_cut_ff);
   assign in_inner = dsq <= DSQ_BITS'(inner_cut_ff);
   assign in_outer = dsq <= DSQ_BITS'(outer_cut_ff);
   assign hit      = b_atom_ff && gate_ff && in_atom && b_ok_ff && (in_inner || in_outer);
   assign b_fire   = b_v_ff && c_en;

   always_comb begin
      if (!hit) begin
         addend_in = '0;
      end else if (in_inner) begin
         addend_in = b_inner_ff;
      end else begin
         addend_in = b_outer_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         c_v_ff    <= 1'b0;
         c_last_ff <= 1'b0;
         gate_ff   <= 1'b0;
      end else begin
         if (c_en) begin
            c_v_ff    <= b_v_ff;
            c_last_ff <= b_v_ff && b_last_ff;
         end
         if (b_fire && !b_atom_ff) begin
            gate_ff <= dsq < DSQ_BITS'(residue_cut_ff);
         end
      end
      if (b_fire) begin
         c_add_ff <= addend_in;
      end
   end

   // stage D: saturating accumulator and result register
   logic signed [SUM_BITS-1:0] sum_ff;
   logic signed [SUM_BITS:0]   wide_sum;
   logic signed [SUM_BITS-1:0] sum_in;
   logic signed [SUM_BITS-1:0] total_ff;
   logic                       c_fire, o_load;

   assign c_fire   = c_v_ff && c_en;
   assign o_load   = c_fire && c_last_ff;
   assign wide_sum = (SUM_BITS+1)'(sum_ff) + (SUM_BITS+1)'(c_add_ff);

   always_comb begin
      if (wide_sum[SUM_BITS] != wide_sum[SUM_BITS-1]) begin
         sum_in = wide_sum[SUM_BITS] ? {1'b1, {(SUM_BITS-1){1'b0}}}
                                     : {1'b0, {(SUM_BITS-1){1'b1}}};
      end else begin
         sum_in = wide_sum[SUM_BITS-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sum_ff <= '0;
         o_v_ff <= 1'b0;
      end else begin
         if (c_fire) begin
            sum_ff <= c_last_ff ? '0 : sum_in;
         end
         if (o_en) begin
            o_v_ff <= o_load;
         end
      end
      if (o_load) begin
         total_ff <= sum_in;
      end
   end

   assign rsp_valid        = o_v_ff;
   assign rsp_total_energy = total_ff;

   // checks
   assert property (@(posedge clock) disable iff (reset)
      o_load |=> (sum_ff == '0) && o_v_ff)
      else $error("sum not cleared after result");

   assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (a_v_ff && b_v_ff && c_v_ff && o_v_ff))
      else $error("input stalled with a free stage");

   assert property (@(posedge clock)
      $past(reset) |-> (!rsp_valid && !gate_ff))
      else $error("state not cleared by reset");

   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> !o_load || !$past(c_v_ff && c_last_ff) || rsp_valid)
      else $error("result overwritten while stalled");

endmodule

FILE: rtl/acpe_table.sv
`timescale 1ns / 1ps

module acpe_table
   import acpe_pkg::*;
(
   input  logic                         clock,
   input  tbl_wr_type                   wr,
   input  tbl_rd_type                   rd,
   output logic signed [ENTRY_BITS-1:0] rd_inner,
   output logic signed [ENTRY_BITS-1:0] rd_outer
);

   localparam int DEPTH = 1 << TADDR_BITS;

   logic signed [ENTRY_BITS-1:0] inner_mem [DEPTH];
   logic signed [ENTRY_BITS-1:0] outer_mem [DEPTH];
   logic signed [ENTRY_BITS-1:0] inner_ff;
   logic signed [ENTRY_BITS-1:0] outer_ff;

   always_ff @(posedge clock) begin
      if (wr.en && !wr.outer) begin
         inner_mem[wr.addr] <= wr.data;
      end
      if (rd.en) begin
         inner_ff <= inner_mem[rd.addr];
      end
   end

   always_ff @(posedge clock) begin
      if (wr.en && wr.outer) begin
         outer_mem[wr.addr] <= wr.data;
      end
      if (rd.en) begin
         outer_ff <= outer_mem[rd.addr];
      end
   end

   assign rd_inner = inner_ff;
   assign rd_outer = outer_ff;

endmodule

FILE: tb/contact_energy_checker.sv
`timescale 1ns / 1ps

module contact_energy_checker
   import acpe_pkg::*;
(
   input  logic                         clock,
   input  logic                         reset,

   input  logic                         req_valid,
   input  logic                         req_stall,
   input  logic [1:0]                   req_action,
   input  logic signed [15:0]           req_receptor_x,
   input  logic signed [15:0]           req_receptor_y,
   input  logic signed [15:0]           req_receptor_z,
   input  logic signed [15:0]           req_ligand_x,
   input  logic signed [15:0]           req_ligand_y,
   input  logic signed [15:0]           req_ligand_z,
   input  logic [TYPE_FIELD_BITS-1:0]   req_receptor_type,
   input  logic [TYPE_FIELD_BITS-1:0]   req_ligand_type,
   input  logic [1:0]                   req_table_select,
   input  logic signed [15:0]           req_table_value,
   input  logic                         req_last,

   input  logic                         rsp_valid,
   input  logic                         rsp_stall,
   input  logic signed [SUM_BITS-1:0]   rsp_total_energy,

   input  logic                         csr_valid,
   input  logic                         csr_ready,
   input  logic [2:0]                   csr_index,
   input  logic [CUT_BITS-1:0]          csr_data,

   output int                           mismatch_count,
   output int                           outstanding
);

   localparam longint SUM_HIGH = 64'sh0000_7FFF_FFFF_FFFF;
   localparam longint SUM_LOW  = -SUM_HIGH - 1;

   logic                         model_sel;
   logic [CUT_BITS-1:0]          residue_limit;
   logic [CUT_BITS-1:0]          atom_limit;
   logic [CUT_BITS-1:0]          inner_limit;
   logic [CUT_BITS-1:0]          outer_limit;
   logic                         gate_open;
   logic signed [SUM_BITS-1:0]   running_sum;
   logic signed [ENTRY_BITS-1:0] energy_entry [0:4*TYPE_COUNT*TYPE_COUNT-1];
   logic signed [SUM_BITS-1:0]   energy_due [$];
   int                           errors = 0;

   initial begin
      mismatch_count = 0;
      outstanding    = 0;
   end

   always @(posedge clock) begin
      longint                     dx;
      longint                     dy;
      longint                     dz;
      longint                     dsq;
      longint                     total;
      logic                       shell_outer;
      logic                       shell_hit;
      action_type                 act;
      logic signed [SUM_BITS-1:0] want;

      if (reset) begin
         model_sel     = 1'b1;
         residue_limit = RESIDUE_CUT_RESET;
         atom_limit    = ATOM_CUT_RESET;
         inner_limit   = INNER_RESET;
         outer_limit   = OUTER_RESET;
         gate_open     = 1'b0;
         running_sum   = '0;
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index_type'(csr_index))
               REG_MODEL:       model_sel     = csr_data[0];
               REG_RESIDUE_CUT: residue_limit = csr_data;
               REG_ATOM_CUT:    atom_limit    = csr_data;
               REG_INNER:       inner_limit   = csr_data;
               REG_OUTER:       outer_limit   = csr_data;
               default: ;
            endcase
         end

         if (req_valid && !req_stall) begin
            act = action_type'(req_action);
            dx  = longint'(req_ligand_x) - longint'(req_receptor_x);
            dy  = longint'(req_ligand_y) - longint'(req_receptor_y);
            dz  = longint'(req_ligand_z) - longint'(req_receptor_z);
            dsq = dx * dx + dy * dy + dz * dz;
            case (act)
               ACT_TABLE:
                  energy_entry[{req_table_select, req_receptor_type, req_ligand_type}] =
                     req_table_value;
               ACT_RESIDUE:
                  gate_open = dsq < longint'(residue_limit);
               ACT_ATOM: begin
                  if (gate_open && dsq <= longint'(atom_limit)) begin
                     shell_hit   = 1'b1;
                     shell_outer = 1'b0;
                     if (dsq <= longint'(inner_limit))
                        shell_outer = 1'b0;
                     else if (dsq <= longint'(outer_limit))
                        shell_outer = 1'b1;
                     else
                        shell_hit = 1'b0;
                     if (shell_hit) begin
                        total = longint'(running_sum) + longint'(energy_entry[
                           {model_sel, shell_outer, req_receptor_type, req_ligand_type}]);
                        if (total > SUM_HIGH) total = SUM_HIGH;
                        if (total < SUM_LOW)  total = SUM_LOW;
                        running_sum = total[SUM_BITS-1:0];
                     end
                  end
               end
               default: ;
            endcase
            if (req_last && (act == ACT_RESIDUE || act == ACT_ATOM)) begin
               energy_due.push_back(running_sum);
               running_sum = '0;
            end
         end

         if (rsp_valid && !rsp_stall) begin
            if (energy_due.size() == 0) begin
               errors++;
               if (errors <= 10)
                  $display("%0t: unexpected result beat, total_energy %0d",
                           $realtime, rsp_total_energy);
            end else begin
               want = energy_due.pop_front();
               if (rsp_total_energy !== want) begin
                  errors++;
                  if (errors <= 10)
                     $display("%0t: total_energy expected %0d, got %0d",
                              $realtime, want, rsp_total_energy);
               end
            end
         end
      end

      mismatch_count <= errors;
      outstanding    <= energy_due.size();
   end

endmodule

FILE: tb/atom_pair_contact_energy_top_tb.sv
`timescale 1ns / 1ps

module atom_pair_contact_energy_top_tb;
   import acpe_pkg::*;

   localparam int QUIET_LIMIT = 4000;

   logic                         clock;
   logic                         reset;

   logic                         req_valid;
   logic                         req_stall;
   logic [1:0]                   req_action;
   logic signed [15:0]           req_receptor_x;
   logic signed [15:0]           req_receptor_y;
   logic signed [15:0]           req_receptor_z;
   logic signed [15:0]           req_ligand_x;
   logic signed [15:0]           req_ligand_y;
   logic signed [15:0]           req_ligand_z;
   logic [TYPE_FIELD_BITS-1:0]   req_receptor_type;
   logic [TYPE_FIELD_BITS-1:0]   req_ligand_type;
   logic [1:0]                   req_table_select;
   logic signed [15:0]           req_table_value;
   logic                         req_last;

   logic                         rsp_valid;
   logic                         rsp_stall = 1'b0;
   logic signed [SUM_BITS-1:0]   rsp_total_energy;

   logic                         csr_valid;
   logic                         csr_ready;
   logic [2:0]                   csr_index;
   logic [CUT_BITS-1:0]          csr_data;

   int                           mismatch_count;
   int                           outstanding;

   int                           send_idle_pct = 21;
   int                           stall_pct = 82;
   int                           phase_items;
   int                           quiet_cycles = 0;

   atom_pair_contact_energy_top DUT (.*);

   contact_energy_checker energy_check (.*);

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   always @(negedge clock) begin
      rsp_stall <= ($urandom_range(0, 99) < stall_pct);
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
          (csr_valid && csr_ready))
         quiet_cycles <= 0;
      else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("FAILURE");
         $finish;
      end else
         quiet_cycles <= quiet_cycles + 1;
   end

   function automatic logic [15:0] rand16();
      return 16'($urandom);
   endfunction

   function automatic logic [1:0] rand2();
      return 2'($urandom);
   endfunction

   function automatic logic rand1();
      return 1'($urandom);
   endfunction

   // atom pairs use types 0..6 and 31 only; all their entries get filled
   function automatic logic [TYPE_FIELD_BITS-1:0] type_code(input int k);
      return (k == 7) ? TYPE_FIELD_BITS'(31) : TYPE_FIELD_BITS'(k);
   endfunction

   function automatic logic [TYPE_FIELD_BITS-1:0] pick_type();
      return type_code(int'($urandom_range(0, 7)));
   endfunction

   task automatic drive_beat(input action_type act,
                             input logic signed [15:0] rx, ry, rz, lx, ly, lz,
                             input logic [TYPE_FIELD_BITS-1:0] rt, lt,
                             input logic [1:0] tsel,
                             input logic signed [15:0] tval,
                             input logic last);
      @(negedge clock);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid         <= 1'b1;
      req_action        <= act;
      req_receptor_x    <= rx;
      req_receptor_y    <= ry;
      req_receptor_z    <= rz;
      req_ligand_x      <= lx;
      req_ligand_y      <= ly;
      req_ligand_z      <= lz;
      req_receptor_type <= rt;
      req_ligand_type   <= lt;
      req_table_select  <= tsel;
      req_table_value   <= tval;
      req_last          <= last;
      do @(posedge clock); while (req_stall);
      if (act != ACT_NONE)
         phase_items++;
   endtask

   // ligand placed at receptor + offset; receptor kept clear of the rails
   task automatic send_contact(input action_type act, input int dx, dy, dz,
                               input logic [TYPE_FIELD_BITS-1:0] rt, lt,
                               input logic last);
      logic signed [15:0] rx;
      logic signed [15:0] ry;
      logic signed [15:0] rz;
      rx = 16'($urandom_range(0, 60000) - 30000);
      ry = 16'($urandom_range(0, 60000) - 30000);
      rz = 16'($urandom_range(0, 60000) - 30000);
      drive_beat(act, rx, ry, rz, 16'(rx + dx), 16'(ry + dy), 16'(rz + dz), rt, lt,
                 rand2(), rand16(), last);
   endtask

   task automatic write_register(input csr_index_type idx, input logic [CUT_BITS-1:0] value);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   function automatic int pick_offset(input logic residue);
      int spread;
      if (residue)
         case ($urandom_range(0, 4))
            0:       spread = 300;
            1:       spread = 900;
            2:       spread = 1000;
            3:       spread = 3000;
            default: spread = 40000;
         endcase
      else
         case ($urandom_range(0, 7))
            0:       spread = 0;
            1:       spread = 16;
            2:       spread = 128;
            3:       spread = 200;
            4:       spread = 260;
            5:       spread = 400;
            6:       spread = 3000;
            default: spread = 40000;
         endcase
      return int'($urandom_range(0, 2 * spread)) - spread;
   endfunction

   initial begin
      int                  phase;
      int                  quota;
      int                  run_len;
      int                  roll;
      logic                sel;
      logic [CUT_BITS-1:0] lim_r;
      logic [CUT_BITS-1:0] lim_a;
      logic [CUT_BITS-1:0] lim_i;
      logic [CUT_BITS-1:0] lim_o;

      reset             = 1'b1;
      req_valid         = 1'b0;
      req_action        = ACT_RESIDUE;
      req_receptor_x    = '0;
      req_receptor_y    = '0;
      req_receptor_z    = '0;
      req_ligand_x      = '0;
      req_ligand_y      = '0;
      req_ligand_z      = '0;
      req_receptor_type = '0;
      req_ligand_type   = '0;
      req_table_select  = '0;
      req_table_value   = '0;
      req_last          = 1'b0;
      csr_valid         = 1'b0;
      csr_index         = REG_MODEL;
      csr_data          = '0;

      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      for (phase = 0; phase < 6; phase++) begin
         if (phase == 2) begin
            send_idle_pct = 82;
            stall_pct     = 21;
         end else if (phase == 4) begin
            send_idle_pct = 0;
            stall_pct     = 0;
         end

         case (phase)
            0: begin
               sel = 1'b1; lim_r = RESIDUE_CUT_RESET; lim_a = ATOM_CUT_RESET;
               lim_i = INNER_RESET; lim_o = OUTER_RESET;
            end
            1: begin
               sel = 1'b0; lim_r = '1; lim_a = '1; lim_i = '0; lim_o = '1;
            end
            2: begin
               sel = 1'b1; lim_r = '0; lim_a = '0; lim_i = '1; lim_o = '0;
            end
            3: begin
               // shells swapped: outer bound below inner bound
               sel = 1'b0; lim_r = RESIDUE_CUT_RESET; lim_a = ATOM_CUT_RESET;
               lim_i = OUTER_RESET; lim_o = INNER_RESET;
            end
            default: begin
               sel   = 1'($urandom_range(0, 1));
               lim_r = CUT_BITS'($urandom_range(600000, 4000000));
               lim_a = CUT_BITS'($urandom_range(20000, 400000));
               lim_i = CUT_BITS'($urandom_range(0, lim_a));
               lim_o = CUT_BITS'($urandom_range(lim_i, lim_a + 100000));
            end
         endcase
         write_register(REG_MODEL, CUT_BITS'(sel));
         write_register(REG_RESIDUE_CUT, lim_r);
         write_register(REG_ATOM_CUT, lim_a);
         write_register(REG_INNER, lim_i);
         write_register(REG_OUTER, lim_o);

         if (phase == 0) begin
            // fill every entry of the types in use so no read hits an unwritten one
            for (int s = 0; s < 4; s++)
               for (int r = 0; r < 8; r++)
                  for (int l = 0; l < 8; l++)
                     drive_beat(ACT_TABLE, rand16(), rand16(), rand16(), rand16(),
                                rand16(), rand16(), type_code(r), type_code(l), 2'(s),
                                rand16(), rand1());

            drive_beat(ACT_RESIDUE, 16'sh8000, 16'sh8000, 16'sh8000,
                       16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 5'd0, 5'd0, 2'd0, 16'sh0000, 1'b0);
            send_contact(ACT_ATOM, 0, 0, 0, 0, 0, 1'b1);
            send_contact(ACT_RESIDUE, 1536, 64, 0, 0, 0, 1'b0);     // on CA limit: closed
            send_contact(ACT_ATOM, 0, 0, 0, 0, 0, 1'b1);
            send_contact(ACT_RESIDUE, -1536, 63, 0, 0, 0, 1'b0);    // just inside: open
            drive_beat(ACT_TABLE, 16'sh0000, 16'sh0000, 16'sh0000, 16'sh0000, 16'sh0000,
                       16'sh0000, 5'd0, 5'd0, 2'd3, 16'sh7FFF, 1'b1);
            send_contact(ACT_ATOM, 320, 0, 0, 0, 0, 1'b0);          // reads fresh entry
            drive_beat(ACT_TABLE, 16'sh0000, 16'sh0000, 16'sh0000, 16'sh0000, 16'sh0000,
                       16'sh0000, 5'd31, 5'd31, 2'd3, 16'sh8000, 1'b0);
            send_contact(ACT_ATOM, 256, 0, 0, 31, 31, 1'b0);        // inner edge
            send_contact(ACT_ATOM, 256, 1, 0, 0, 0, 1'b0);
            send_contact(ACT_ATOM, 0, -384, 0, 31, 31, 1'b0);       // outer edge
            send_contact(ACT_ATOM, 384, 1, 0, 0, 0, 1'b0);          // past both shells
            send_contact(ACT_ATOM, 384, 64, 64, 0, 0, 1'b0);        // on atom limit
            send_contact(ACT_ATOM, -384, -64, -65, 0, 0, 1'b0);     // past atom limit
            drive_beat(ACT_NONE, 16'sh1234, 16'sh0000, 16'sh0000, 16'sh1234, 16'sh0000,
                       16'sh0000, 5'd3, 5'd4, 2'd1, 16'sh0001, 1'b1);
            send_contact(ACT_ATOM, 0, 0, -256, 31, 31, 1'b1);
            send_contact(ACT_ATOM, 0, 0, 0, 31, 31, 1'b1);          // gate held across beats
            drive_beat(ACT_TABLE, 16'sh7FFF, 16'sh8000, 16'sh7FFF, 16'sh8000, 16'sh7FFF,
                       16'sh8000, 5'd31, 5'd0, 2'd0, 16'shFFFF, 1'b0);
            drive_beat(ACT_RESIDUE, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF,
                       16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 5'd31, 5'd31, 2'd3, 16'sh7FFF, 1'b1);
         end

         phase_items = 0;
         quota = (phase == 2) ? 60 : 183;
         while (phase_items < quota) begin
            roll = $urandom_range(0, 99);
            if (roll < 6)
               drive_beat(action_type'($urandom_range(0, 3)), rand16(), rand16(), rand16(),
                          rand16(), rand16(), rand16(), pick_type(), pick_type(), rand2(),
                          rand16(), rand1());
            else if (roll < 14)
               drive_beat(ACT_TABLE, rand16(), rand16(), rand16(), rand16(), rand16(),
                          rand16(), TYPE_FIELD_BITS'($urandom), TYPE_FIELD_BITS'($urandom),
                          rand2(), rand16(), rand1());
            else begin
               send_contact(ACT_RESIDUE, pick_offset(1'b1), pick_offset(1'b1),
                            pick_offset(1'b1), pick_type(), pick_type(),
                            $urandom_range(0, 19) == 0);
               run_len = $urandom_range(1, 12);
               for (int k = 1; k <= run_len; k++) begin
                  if ($urandom_range(0, 9) == 0)
                     drive_beat(ACT_TABLE, rand16(), rand16(), rand16(), rand16(), rand16(),
                                rand16(), TYPE_FIELD_BITS'($urandom),
                                TYPE_FIELD_BITS'($urandom), rand2(), rand16(), rand1());
                  send_contact(ACT_ATOM, pick_offset(1'b0), pick_offset(1'b0),
                               pick_offset(1'b0), pick_type(), pick_type(),
                               (k == run_len) ? ($urandom_range(0, 9) != 0)
                                              : ($urandom_range(0, 29) == 0));
               end
            end
         end

         // drain before touching registers
         @(negedge clock);
         req_valid <= 1'b0;
         while (outstanding != 0) @(posedge clock);
         repeat (8) @(posedge clock);
      end

      repeat (10) @(posedge clock);
      if (mismatch_count == 0 && outstanding == 0)
         $display("SUCCESS");
      else
         $display("FAILURE");
      $finish;
   end

endmodule
